### hdl/zrvd_pkg.sv
`default_nettype none

package zrvd_pkg;

  localparam int unsigned MAX_LEAVES = 4096;
  localparam int unsigned LeafW = 13;
  localparam int unsigned LenW = 10;
  localparam int unsigned RowCapRaw = (MAX_LEAVES + 7) / 8;
  localparam int unsigned RowCapLim = (RowCapRaw > 512) ? 512 : RowCapRaw;
  localparam int unsigned RowCap = (RowCapLim == 0) ? 1 : RowCapLim;

  localparam logic [7:0] ByteOnes = 8'hFF;
  localparam logic [7:0] ByteZero = 8'h00;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [63:0] row_word;
    logic [5:0]  word_index;
    logic [3:0]  bytes_valid;
    logic        last_of_row;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FILL
  } state_e;

  typedef enum logic [1:0] {
    SEL_LITERAL,
    SEL_ZERO,
    SEL_ONES
  } byte_sel_e;

  typedef struct packed {
    logic      push;
    byte_sel_e byte_sel;
    logic      clear_row;
    logic      load_cnt;
    logic      set_expect;
    logic      clr_expect;
  } dp_cmd_t;

  typedef struct packed {
    logic can_push;
    logic row_last;
    logic cnt_one;
    logic expect_count;
  } dp_stat_t;

  // row length in bytes: ceil(leaves/8), zero taken as one leaf, capped
  function automatic logic [LenW-1:0] row_length(input logic [LeafW-1:0] leaves);
    logic [LeafW:0] sum;
    logic [LeafW:0] len;
    sum = (leaves == '0) ? (LeafW+1)'(8) : ({1'b0, leaves} + (LeafW+1)'(7));
    len = sum >> 3;
    if (len > (LeafW+1)'(RowCap)) begin
      len = (LeafW+1)'(RowCap);
    end
    return len[LenW-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/zero_run_visibility_decoder.sv
// output: a word completed by a literal byte is registered, shown the cycle after its beat
// throughput: one literal byte per cycle, held off by output stalls; runs and fills push
//   one row byte per cycle, also held off by output stalls, through the single byte-insert
//   datapath; input stalls while a run of n zeros is pushed (fewer where the row ends first)
//   or while a fill pushes the row length, ceil(leaf_count/8), zero as one leaf, capped at 512
// reset: asynchronous active low; clears decoder state and sets leaf_count to 4096
`default_nettype none

module zero_run_visibility_decoder (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // compressed byte stream
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  zrvd_pkg::in_t   in_data_i,
  // decompressed row words
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output       zrvd_pkg::out_t  out_data_o,
  // configuration port
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  logic [2:0]      paddr,
  input  wire  logic [31:0]     pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // leaf count register, the only one, decoded at byte addresses 0 to 3 (paddr[2] low)
  logic [zrvd_pkg::LeafW-1:0] leaf_count_q, leaf_count_d;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_comb begin
    leaf_count_d = leaf_count_q;
    if (cfg_wr) begin
      leaf_count_d = pwdata[zrvd_pkg::LeafW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= zrvd_pkg::LeafW'(4096);
    end else begin
      leaf_count_q <= leaf_count_d;
    end
  end

  // reads of any address with paddr[2] set give zero
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - zrvd_pkg::LeafW){1'b0}}, leaf_count_q} : 32'd0;

  // controller and datapath talk only through command and status groups
  zrvd_pkg::dp_cmd_t  cmd;
  zrvd_pkg::dp_stat_t stat;

  zrvd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // byte insert, row counters and the output word register
  zrvd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .leaf_count_i (leaf_count_q),
    .data_byte_i  (in_data_i.data_byte),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // a word that does not close the row is always full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last_of_row) |-> (out_data_o.bytes_valid == 4'd8))
    else $error("short word before row end");

  // byte count of a word stays in one to eight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.bytes_valid != 4'd0) && (out_data_o.bytes_valid <= 4'd8)))
    else $error("bytes_valid out of range");

  // a fill beat holds off the next beat while the row is produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.action) |=> in_stall_o)
    else $error("input taken during fill");

endmodule

`default_nettype wire

### hdl/zrvd_datapath.sv
`default_nettype none

module zrvd_datapath (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire  logic [zrvd_pkg::LeafW-1:0] leaf_count_i,
  input  wire  logic [7:0]                data_byte_i,
  input  wire  zrvd_pkg::dp_cmd_t         cmd_i,
  output       zrvd_pkg::dp_stat_t        stat_o,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output       zrvd_pkg::out_t            out_data_o
);

  logic [63:0]               buf_q, buf_d;
  logic [2:0]                slot_q, slot_d;
  logic [zrvd_pkg::LenW-1:0] rbd_q, rbd_d;
  logic [7:0]                cnt_q, cnt_d;
  logic                      expect_q, expect_d;
  logic                      ovalid_q, ovalid_d;
  zrvd_pkg::out_t            odata_q, odata_d;

  logic [zrvd_pkg::LenW-1:0] len;
  logic [zrvd_pkg::LenW-1:0] rbd_next;
  logic                      last;
  logic                      emit;
  logic                      can_push;
  logic [7:0]                b_sel;
  logic [63:0]               merged;

  assign len      = zrvd_pkg::row_length(leaf_count_i);
  assign rbd_next = rbd_q + zrvd_pkg::LenW'(1);
  assign last     = (rbd_next >= len);
  assign emit     = (slot_q == 3'd7) || last;
  assign can_push = !ovalid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.byte_sel)
      zrvd_pkg::SEL_LITERAL: b_sel = data_byte_i;
      zrvd_pkg::SEL_ZERO:    b_sel = zrvd_pkg::ByteZero;
      zrvd_pkg::SEL_ONES:    b_sel = zrvd_pkg::ByteOnes;
      default:               b_sel = zrvd_pkg::ByteZero;
    endcase
  end

  assign merged = buf_q | (64'(b_sel) << {slot_q, 3'b000});

  always_comb begin
    buf_d    = buf_q;
    slot_d   = slot_q;
    rbd_d    = rbd_q;
    cnt_d    = cnt_q;
    expect_d = expect_q;
    ovalid_d = ovalid_q && out_stall_i;
    odata_d  = odata_q;

    if (cmd_i.clear_row) begin
      buf_d  = '0;
      slot_d = '0;
      rbd_d  = '0;
    end
    if (cmd_i.set_expect) begin
      expect_d = 1'b1;
    end
    if (cmd_i.clr_expect) begin
      expect_d = 1'b0;
    end
    if (cmd_i.load_cnt) begin
      cnt_d = data_byte_i;
    end
    if (cmd_i.push) begin
      if (cmd_i.byte_sel == zrvd_pkg::SEL_ZERO) begin
        cnt_d = cnt_q - 8'd1;
      end
      if (emit) begin
        ovalid_d            = 1'b1;
        odata_d.row_word    = merged;
        odata_d.word_index  = rbd_q[8:3];
        odata_d.bytes_valid = {1'b0, slot_q} + 4'd1;
        odata_d.last_of_row = last;
        buf_d  = '0;
        slot_d = '0;
        rbd_d  = last ? '0 : rbd_next;
      end else begin
        buf_d  = merged;
        slot_d = slot_q + 3'd1;
        rbd_d  = rbd_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q    <= '0;
      slot_q   <= '0;
      rbd_q    <= '0;
      cnt_q    <= '0;
      expect_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      buf_q    <= buf_d;
      slot_q   <= slot_d;
      rbd_q    <= rbd_d;
      cnt_q    <= cnt_d;
      expect_q <= expect_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
  end

  assign stat_o.can_push     = can_push;
  assign stat_o.row_last     = last;
  assign stat_o.cnt_one      = (cnt_q == 8'd1);
  assign stat_o.expect_count = expect_q;
  assign out_valid_o         = ovalid_q;
  assign out_data_o          = odata_q;

endmodule

`default_nettype wire

### hdl/zrvd_ctrl.sv
`default_nettype none

module zrvd_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  input  wire  zrvd_pkg::in_t       in_data_i,
  output logic                      in_stall_o,
  input  wire  zrvd_pkg::dp_stat_t  stat_i,
  output       zrvd_pkg::dp_cmd_t   cmd_o
);

  zrvd_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_stall_o = (state_q != zrvd_pkg::ST_IDLE) || !stat_i.can_push;
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      zrvd_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data_i.action) begin
            state_d = zrvd_pkg::ST_FILL;
          end else if (stat_i.expect_count && (in_data_i.data_byte != 8'd0)) begin
            state_d = zrvd_pkg::ST_RUN;
          end
        end
      end
      zrvd_pkg::ST_RUN: begin
        if (stat_i.can_push && (stat_i.row_last || stat_i.cnt_one)) begin
          state_d = zrvd_pkg::ST_IDLE;
        end
      end
      zrvd_pkg::ST_FILL: begin
        if (stat_i.can_push && stat_i.row_last) begin
          state_d = zrvd_pkg::ST_IDLE;
        end
      end
      default: state_d = zrvd_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.byte_sel = zrvd_pkg::SEL_LITERAL;
    case (state_q)
      zrvd_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data_i.action) begin
            cmd_o.clear_row  = 1'b1;
            cmd_o.clr_expect = 1'b1;
          end else if (stat_i.expect_count) begin
            cmd_o.clr_expect = 1'b1;
            cmd_o.load_cnt   = (in_data_i.data_byte != 8'd0);
          end else if (in_data_i.data_byte == 8'd0) begin
            cmd_o.set_expect = 1'b1;
          end else begin
            cmd_o.push = 1'b1;
          end
        end
      end
      zrvd_pkg::ST_RUN: begin
        cmd_o.byte_sel = zrvd_pkg::SEL_ZERO;
        cmd_o.push     = stat_i.can_push;
      end
      zrvd_pkg::ST_FILL: begin
        cmd_o.byte_sel = zrvd_pkg::SEL_ONES;
        cmd_o.push     = stat_i.can_push;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zrvd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### verif/zero_run_visibility_decoder_tb.sv
module zero_run_visibility_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_FILL = 1'b1;

  // register addresses: leaf_count is the only register, the next slot is unused
  localparam logic [2:0] LEAF_ADDR  = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  // cycles with no beat on either side and no bus access before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // settle time after the last expected word, before a register write or the end
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned RANDOM_BEATS = 170;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  zrvd_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  zrvd_pkg::out_t out_data_o;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  zero_run_visibility_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the decoder and its register
  // ---------------------------------------------------------------------------
  logic [12:0] vis_leaves;
  logic        pend_count;
  logic [63:0] word_acc;
  logic [2:0]  slot;
  logic [9:0]  row_done;

  // decompressed words still owed by the block, oldest first
  zrvd_pkg::out_t words_due[$];

  int unsigned fail_count;
  int unsigned beats_sent;
  int unsigned words_seen;
  int unsigned cfg_writes;
  int unsigned quiet_cycles;
  int unsigned hold_cycles;
  bit          idle_on;

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // reference arithmetic
  // ---------------------------------------------------------------------------

  // row length in bytes: zero leaves counts as one, capped at the word_index reach
  function automatic logic [9:0] row_len_of(input logic [12:0] leaves);
    int unsigned n;
    int unsigned cap;
    cap = (zrvd_pkg::MAX_LEAVES + 7) / 8;
    if (cap > 512) cap = 512;
    if (cap == 0) cap = 1;
    n = (leaves == '0) ? 1 : leaves;
    n = (n + 7) / 8;
    if (n > cap) n = cap;
    return 10'(n);
  endfunction

  // drop one row byte into the word being built; returns 1 when the row closes
  function automatic bit push_row_byte(input logic [7:0] b);
    zrvd_pkg::out_t w;
    logic [9:0]     len;
    logic [9:0]     pos;
    bit             closes;
    len = row_len_of(vis_leaves);
    word_acc[{slot, 3'b000} +: 8] = b;
    row_done = row_done + 10'd1;
    closes = (row_done >= len);
    if (slot == 3'd7 || closes) begin
      pos           = row_done - 10'd1;
      w.row_word    = word_acc;
      w.word_index  = pos[8:3];
      w.bytes_valid = {1'b0, slot} + 4'd1;
      w.last_of_row = closes;
      words_due.push_back(w);
      word_acc = '0;
      slot     = '0;
      if (closes) row_done = '0;
    end else begin
      slot = slot + 3'd1;
    end
    return closes;
  endfunction

  // expected words for one accepted input beat
  function automatic void decode_beat(input zrvd_pkg::in_t beat);
    logic [9:0] len;
    int unsigned i;
    bit         closed;
    closed = 1'b0;
    if (beat.action == ACT_FILL) begin
      // a fill throws away any partial row and pending count
      len        = row_len_of(vis_leaves);
      pend_count = 1'b0;
      word_acc   = '0;
      slot       = '0;
      row_done   = '0;
      for (i = 0; i < len && !closed; i++) closed = push_row_byte(zrvd_pkg::ByteOnes);
    end else if (pend_count) begin
      // run count: zeros past the row end are dropped
      pend_count = 1'b0;
      for (i = 0; i < beat.data_byte && !closed; i++) closed = push_row_byte(zrvd_pkg::ByteZero);
    end else if (beat.data_byte == zrvd_pkg::ByteZero) begin
      pend_count = 1'b1;
    end else begin
      void'(push_row_byte(beat.data_byte));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // monitor: predicts on every input beat, checks every output beat
  // input is handled first so a same-edge word still finds its expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    zrvd_pkg::out_t want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == LEAF_ADDR) begin
        vis_leaves = pwdata[12:0];
      end
      if (in_valid_i && !in_stall_o) begin
        decode_beat(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        words_seen++;
        if (words_due.size() == 0) begin
          report_mismatch("word with nothing expected", out_data_o.row_word, '0);
        end else begin
          want = words_due.pop_front();
          if (out_data_o.row_word !== want.row_word)
            report_mismatch("row_word", out_data_o.row_word, want.row_word);
          if (out_data_o.word_index !== want.word_index)
            report_mismatch("word_index", 64'(out_data_o.word_index), 64'(want.word_index));
          if (out_data_o.bytes_valid !== want.bytes_valid)
            report_mismatch("bytes_valid", 64'(out_data_o.bytes_valid),
                            64'(want.bytes_valid));
          if (out_data_o.last_of_row !== want.last_of_row)
            report_mismatch("last_of_row", 64'(out_data_o.last_of_row),
                            64'(want.last_of_row));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: counts cycles with no bus access in which no beat moves on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired, %0d words still owed", $time, words_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, or a long hold when a test asks for one
  // ---------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        // long hold, counted here so the sender keeps pushing meanwhile
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender and configuration helpers
  // ---------------------------------------------------------------------------

  // one input beat: optional gap, then hold the payload until accepted
  // called and returns at a falling edge
  task automatic send_beat(input logic act, input logic [7:0] b);
    zrvd_pkg::in_t beat;
    beat.action    = act;
    beat.data_byte = b;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // drop valid, wait for every owed word, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (words_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register write: setup then access phase, only with the block idle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // read leaf_count back and compare with the predictor's copy
  // the bus is left idle first so it drops between transfers
  task automatic check_leaves_readback();
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LEAF_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {19'd0, vis_leaves})
      report_mismatch("leaf_count readback", 64'(got), 64'(vis_leaves));
  endtask

  task automatic set_leaves(input logic [12:0] leaves);
    write_reg(LEAF_ADDR, {19'd0, leaves});
    check_leaves_readback();
  endtask

  // well-formed compressed row: literals and zero runs adding up to the row length
  task automatic send_row();
    int unsigned left;
    int unsigned run;
    left = 32'(row_len_of(vis_leaves));
    while (left > 0) begin
      if ((left > 16 && $urandom_range(0, 1) == 0) || $urandom_range(0, 3) == 0) begin
        run = $urandom_range(1, (left < 255) ? left : 255);
        send_beat(ACT_BYTE, zrvd_pkg::ByteZero);
        send_beat(ACT_BYTE, 8'(run));
        left -= run;
      end else begin
        send_beat(ACT_BYTE, 8'($urandom_range(1, 255)));
        left--;
      end
    end
  endtask

  // a few unstructured beats: any byte, the odd fill, overlong runs
  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 7) == 0) begin
        send_beat(ACT_FILL, 8'($urandom));
      end else begin
        send_beat(ACT_BYTE, 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // register comes out of reset at 4096 leaves: a fill gives a full 64-word row
  task automatic test_reset_fill();
    check_leaves_readback();
    send_beat(ACT_FILL, 8'hA5);
  endtask

  // literals at the byte extremes, a short run, an empty run, and a run past row end
  task automatic test_literals_and_runs();
    set_leaves(13'd100);
    send_beat(ACT_BYTE, 8'h01);
    send_beat(ACT_BYTE, 8'h80);
    send_beat(ACT_BYTE, 8'hFF);
    send_beat(ACT_BYTE, 8'h7F);
    send_beat(ACT_BYTE, zrvd_pkg::ByteZero);
    send_beat(ACT_BYTE, 8'd3);
    send_beat(ACT_BYTE, 8'hAA);
    // empty run emits nothing
    send_beat(ACT_BYTE, zrvd_pkg::ByteZero);
    send_beat(ACT_BYTE, 8'd0);
    // 255 zeros, clipped at the row end
    send_beat(ACT_BYTE, zrvd_pkg::ByteZero);
    send_beat(ACT_BYTE, 8'd255);
  endtask

  // fill arriving with a partial row and a pending count discards both
  task automatic test_fill_mid_row();
    send_beat(ACT_BYTE, 8'h55);
    send_beat(ACT_BYTE, zrvd_pkg::ByteZero);
    send_beat(ACT_FILL, zrvd_pkg::ByteZero);
  endtask

  // zero leaves behaves as one: one-byte rows
  task automatic test_tiny_rows();
    set_leaves(13'd0);
    send_beat(ACT_BYTE, 8'h01);
    send_beat(ACT_FILL, 8'hFF);
  endtask

  // row length cut below what the current row already holds
  task automatic test_shortened_row();
    set_leaves(13'd100);
    send_beat(ACT_BYTE, 8'h11);
    send_beat(ACT_BYTE, 8'h22);
    send_beat(ACT_BYTE, 8'h33);
    set_leaves(13'd9);
    send_beat(ACT_BYTE, 8'h44);
  endtask

  // largest leaf count saturates at 512 bytes; writes past the register list do nothing
  task automatic test_cap_and_spare_addr();
    set_leaves(13'h1FFF);
    send_beat(ACT_FILL, 8'h00);
    set_leaves(13'd16);
    write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
    check_leaves_readback();
    send_beat(ACT_FILL, 8'h3C);
  endtask

  // receiver holds off while one-byte rows keep arriving, so the block backs up
  task automatic test_backpressure();
    set_leaves(13'd8);
    hold_cycles = 150;
    repeat (25) send_beat(ACT_BYTE, 8'($urandom_range(1, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // random test: phases at random row lengths, mostly well-formed rows
  // ---------------------------------------------------------------------------
  task automatic test_random_rows();
    int unsigned start;
    int unsigned pick;
    logic [12:0] leaves;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: leaves = 13'd1;
        1: leaves = 13'd8;
        2: leaves = 13'($urandom_range(2, 64));
        3: leaves = 13'($urandom_range(65, 400));
        4: leaves = 13'd4096;
        5: leaves = 13'h1FFF;
        6: leaves = 13'($urandom_range(1, 8191));
        default: leaves = 13'($urandom_range(9, 120));
      endcase
      // big rows are slow, so keep them to the odd phase
      if (row_len_of(leaves) > 64 && $urandom_range(0, 2) != 0) begin
        leaves = 13'($urandom_range(1, 200));
      end
      set_leaves(leaves);
      repeat ($urandom_range(1, 4)) begin
        // the tail of the run goes without any idling
        if (beats_sent - start > RANDOM_BEATS * 85 / 100) idle_on = 1'b0;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_row();
        end else if (pick < 8) begin
          send_beat(ACT_FILL, 8'($urandom));
        end else begin
          send_noise();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count  = 0;
    beats_sent  = 0;
    words_seen  = 0;
    cfg_writes  = 0;
    quiet_cycles = 0;
    hold_cycles = 0;
    idle_on     = 1'b1;
    vis_leaves  = 13'd4096;
    pend_count  = 1'b0;
    word_acc    = '0;
    slot        = '0;
    row_done    = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_fill();
    test_literals_and_runs();
    test_fill_mid_row();
    test_tiny_rows();
    test_shortened_row();
    test_cap_and_spare_addr();
    test_backpressure();
    test_random_rows();

    idle_on = 1'b0;
    wait_idle();
    repeat (20) @(negedge clk_i);

    $display("covered %0d input beats, %0d row words checked, %0d register writes",
             beats_sent, words_seen, cfg_writes);
    $display("row lengths from one byte to the 512-byte cap, fills, clipped runs, long hold");
    if (fail_count == 0 && words_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d words never arrived", fail_count, words_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
